### rtl/wlm_pkg.sv
// Shared types, codes and default sizes of the window lock manager.
package wlm_pkg;

    localparam int MAX_WINDOWS_DEF = 16;
    localparam int MAX_RANKS_DEF   = 64;

    localparam int CMD_W   = 3;
    localparam int RANK_W  = 6;
    localparam int WIN_W   = 4;
    localparam int ERR_W   = 2;
    localparam int NRANK_W = 7;

    localparam logic [NRANK_W-1:0] NUM_RANKS_RST = 7'd64;

    localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOCK   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UNLOCK = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd4;

    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_NO_WINDOW = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL      = 2'd2;
    localparam logic [ERR_W-1:0] ERR_RANK      = 2'd3;

    // One lock table entry as it is stored in memory.
    typedef struct packed {
        logic              held;
        logic [RANK_W-1:0] owner;
        logic              shared;
    } entry_t;

endpackage

### rtl/wlm_if.sv
// Valid/ready channel interfaces for command and response words.
interface wlm_cmd_if
    import wlm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [RANK_W-1:0] requester;
    logic [WIN_W-1:0]  window;
    logic [RANK_W-1:0] target;
    logic              shared;

    modport source (output valid, output command, output requester, output window,
                    output target, output shared, input ready);
    modport sink (input valid, input command, input requester, input window,
                  input target, input shared, output ready);
endinterface

interface wlm_rsp_if
    import wlm_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             granted;
    logic [ERR_W-1:0] error;

    modport source (output valid, output granted, output error, input ready);
    modport sink (input valid, input granted, input error, output ready);
endinterface

### rtl/wlm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module wlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/window_lock_manager.sv
// Window lock manager: lock table for remote memory windows, top level.
//
// Usage: command words arrive on the cmd channel and every command gives
// exactly one response word (granted, error) on the rsp channel. Both are
// valid/ready channels; a word moves at a clock edge with valid and ready high.
// num_ranks is written through cfg_we/cfg_wdata while the block is idle.
//
// Table access: the lock table sits in one RAM with a registered
// read. Lock, unlock, get and set read the entry in the accept cycle, then
// decide, write back and load the response register in the lookup state once
// the response slot is free; a new command word is taken only after that.
// Rejected commands go to the response state instead. A successful create
// clears one entry per cycle before its response; none when num_ranks is zero.
//
// Reset: rst_n clears the window count, sets num_ranks to 64 and empties
// the response register. The table itself is not cleared; create clears the
// entries of a new window. No clearing pass runs after reset.
//
// Stalls: the response register frees the command side; a finished response
// may wait while the next command is read. If a second response is ready
// while the first still waits, the block holds in place until rsp.ready.
module window_lock_manager
    import wlm_pkg::*;
#(
    parameter int MAX_WINDOWS = MAX_WINDOWS_DEF,
    parameter int MAX_RANKS   = MAX_RANKS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [NRANK_W-1:0] cfg_wdata,
    wlm_cmd_if.sink            cmd,
    wlm_rsp_if.source          rsp
);

    localparam int DEPTH = MAX_WINDOWS * MAX_RANKS;
    localparam int AW    = $clog2(DEPTH);
    localparam int WCW   = $clog2(MAX_WINDOWS + 1);
    localparam int CW    = $clog2(MAX_RANKS + 1);
    localparam int EW    = $bits(entry_t);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_CLEAR,
        S_RESP
    } state_t;

    state_t             state_reg, state_next;
    logic [NRANK_W-1:0] nranks_reg, nranks_next;
    logic [WCW-1:0]     wc_reg, wc_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CMD_W-1:0]   op_reg, op_next;
    logic [RANK_W-1:0]  req_reg, req_next;
    logic               shr_reg, shr_next;
    logic               pgrant_reg, pgrant_next;
    logic [ERR_W-1:0]   perr_reg, perr_next;
    logic               ovalid_reg, ovalid_next;
    logic               ogrant_reg, ogrant_next;
    logic [ERR_W-1:0]   oerr_reg, oerr_next;

    logic [CW-1:0]      ranks_eff;
    logic [AW-1:0]      lookup_addr;
    logic [AW-1:0]      create_base;
    logic               slot_free;
    logic               accept;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    entry_t             ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [EW-1:0]      ram_rdata;
    entry_t             rd_entry;
    logic               is_owner;

    // Entry storage: held flag, owner rank and shared flag in one word.
    wlm_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // num_ranks above the table size acts as the table size.
    assign ranks_eff = (32'(nranks_reg) > 32'(MAX_RANKS)) ? CW'(MAX_RANKS)
                                                         : CW'(nranks_reg);

    assign lookup_addr = AW'(32'(cmd.window) * 32'(MAX_RANKS) + 32'(cmd.target));
    assign create_base = AW'(32'(wc_reg) * 32'(MAX_RANKS));

    assign slot_free = !ovalid_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;

    // While a lookup waits for the response slot, the address holds, so the
    // read data stays on the same entry.
    assign ram_raddr = (state_reg == S_IDLE) ? lookup_addr : addr_reg;
    assign rd_entry  = entry_t'(ram_rdata);
    assign is_owner  = rd_entry.held && (rd_entry.owner == req_reg);

    assign rsp.valid   = ovalid_reg;
    assign rsp.granted = ogrant_reg;
    assign rsp.error   = oerr_reg;

    always_comb
    begin
        state_next  = state_reg;
        nranks_next = nranks_reg;
        wc_next     = wc_reg;
        addr_next   = addr_reg;
        cnt_next    = cnt_reg;
        op_next     = op_reg;
        req_next    = req_reg;
        shr_next    = shr_reg;
        pgrant_next = pgrant_reg;
        perr_next   = perr_reg;
        ovalid_next = ovalid_reg;
        ogrant_next = ogrant_reg;
        oerr_next   = oerr_reg;
        ram_we      = 1'b0;
        ram_waddr   = addr_reg;
        ram_wdata   = '0;

        if (cfg_we)
        begin
            nranks_next = cfg_wdata;
        end

        if (rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = cmd.command;
                    req_next    = cmd.requester;
                    shr_next    = cmd.shared;
                    pgrant_next = 1'b0;
                    perr_next   = ERR_NONE;
                    state_next  = S_RESP;
                    if (cmd.command == CMD_CREATE)
                    begin
                        if (32'(wc_reg) >= 32'(MAX_WINDOWS))
                        begin
                            perr_next = ERR_FULL;
                        end
                        else
                        begin
                            wc_next     = WCW'(32'(wc_reg) + 32'd1);
                            pgrant_next = 1'b1;
                            addr_next   = create_base;
                            cnt_next    = CW'(32'(ranks_eff) - 32'd1);
                            if (ranks_eff != '0)
                            begin
                                state_next = S_CLEAR;
                            end
                        end
                    end
                    else if (cmd.command > CMD_SET)
                    begin
                        perr_next = ERR_NONE;
                    end
                    else if (32'(cmd.window) >= 32'(wc_reg))
                    begin
                        perr_next = ERR_NO_WINDOW;
                    end
                    else if (32'(cmd.target) >= 32'(ranks_eff) ||
                             32'(cmd.requester) >= 32'(ranks_eff))
                    begin
                        perr_next = ERR_RANK;
                    end
                    else
                    begin
                        addr_next  = lookup_addr;
                        state_next = S_LOOKUP;
                    end
                end
            end

            S_LOOKUP:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    oerr_next   = ERR_NONE;
                    state_next  = S_IDLE;
                    case (op_reg)
                        CMD_LOCK:
                        begin
                            ogrant_next = !rd_entry.held;
                            ram_we      = !rd_entry.held;
                            ram_wdata   = '{held: 1'b1, owner: req_reg, shared: shr_reg};
                        end
                        CMD_UNLOCK:
                        begin
                            ogrant_next = is_owner;
                            ram_we      = is_owner;
                            ram_wdata   = '0;
                        end
                        CMD_GET:
                        begin
                            ogrant_next = !rd_entry.held || is_owner || rd_entry.shared;
                        end
                        default:
                        begin
                            ogrant_next = !rd_entry.held || is_owner;
                        end
                    endcase
                end
            end

            S_CLEAR:
            begin
                // One entry of the new window per cycle.
                ram_we    = 1'b1;
                ram_wdata = '0;
                addr_next = AW'(32'(addr_reg) + 32'd1);
                cnt_next  = CW'(32'(cnt_reg) - 32'd1);
                if (cnt_reg == '0)
                begin
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    ogrant_next = pgrant_reg;
                    oerr_next   = perr_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            nranks_reg <= NUM_RANKS_RST;
            wc_reg     <= '0;
            addr_reg   <= '0;
            cnt_reg    <= '0;
            op_reg     <= CMD_CREATE;
            req_reg    <= '0;
            shr_reg    <= 1'b0;
            pgrant_reg <= 1'b0;
            perr_reg   <= ERR_NONE;
            ovalid_reg <= 1'b0;
            ogrant_reg <= 1'b0;
            oerr_reg   <= ERR_NONE;
        end
        else
        begin
            state_reg  <= state_next;
            nranks_reg <= nranks_next;
            wc_reg     <= wc_next;
            addr_reg   <= addr_next;
            cnt_reg    <= cnt_next;
            op_reg     <= op_next;
            req_reg    <= req_next;
            shr_reg    <= shr_next;
            pgrant_reg <= pgrant_next;
            perr_reg   <= perr_next;
            ovalid_reg <= ovalid_next;
            ogrant_reg <= ogrant_next;
            oerr_reg   <= oerr_next;
        end
    end

endmodule

### test/window_lock_manager_checker.sv
// Passive lock table predictor and response comparator for the window lock manager bench.
module window_lock_manager_checker
    import wlm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [NRANK_W-1:0] cfg_wdata,
    wlm_cmd_if                 cmd,
    wlm_rsp_if                 rsp,
    output int                 pending,
    output int                 fail_count
);

    localparam int WINDOWS = MAX_WINDOWS_DEF;
    localparam int RANKS   = MAX_RANKS_DEF;

    typedef struct packed {
        logic             granted;
        logic [ERR_W-1:0] error;
    } verdict_t;

    entry_t             lock_table [WINDOWS*RANKS];
    int                 windows_made;
    logic [NRANK_W-1:0] num_ranks;
    verdict_t           verdicts_due [$];
    int                 mismatches;

    // Ranks in use, saturated to the table width.
    function automatic int active_ranks();
        return (int'(num_ranks) > RANKS) ? RANKS : int'(num_ranks);
    endfunction

    // Applies one command word to the predicted table and returns its verdict.
    function automatic verdict_t decide_request(logic [CMD_W-1:0] op,
                                                logic [RANK_W-1:0] req,
                                                logic [WIN_W-1:0] win,
                                                logic [RANK_W-1:0] tgt,
                                                logic shr);
        int       ranks;
        int       slot;
        entry_t   ent;
        logic     owns;
        verdict_t v;
        ranks = active_ranks();
        v.granted = 1'b0;
        v.error = ERR_NONE;
        if (op == CMD_CREATE)
        begin
            if (windows_made >= WINDOWS)
            begin
                v.error = ERR_FULL;
            end
            else
            begin
                for (int r = 0; r < ranks; r++)
                begin
                    lock_table[windows_made*RANKS + r] = '0;
                end
                windows_made++;
                v.granted = 1'b1;
            end
            return v;
        end
        if (op > CMD_SET)
        begin
            return v;
        end
        if (int'(win) >= windows_made)
        begin
            v.error = ERR_NO_WINDOW;
            return v;
        end
        if (int'(tgt) >= ranks || int'(req) >= ranks)
        begin
            v.error = ERR_RANK;
            return v;
        end
        slot = int'(win)*RANKS + int'(tgt);
        ent = lock_table[slot];
        owns = ent.held && (ent.owner == req);
        case (op)
            CMD_LOCK:
            begin
                if (!ent.held)
                begin
                    lock_table[slot].held = 1'b1;
                    lock_table[slot].owner = req;
                    lock_table[slot].shared = shr;
                    v.granted = 1'b1;
                end
            end
            CMD_UNLOCK:
            begin
                if (owns)
                begin
                    lock_table[slot] = '0;
                    v.granted = 1'b1;
                end
            end
            CMD_GET:
            begin
                v.granted = !ent.held || owns || ent.shared;
            end
            default:
            begin
                v.granted = !ent.held || owns;
            end
        endcase
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        verdict_t got;
        if (!rst_n)
        begin
            windows_made = 0;
            num_ranks = NUM_RANKS_RST;
            verdicts_due.delete();
            mismatches = 0;
            pending <= 0;
            fail_count <= 0;
        end
        else
        begin
            // Responses are retired before new commands are predicted, since a
            // response can never belong to a word accepted at the same edge.
            if (rsp.valid && rsp.ready)
            begin
                got.granted = rsp.granted;
                got.error = rsp.error;
                if (verdicts_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Mismatch: response word granted=%0b error=%0d with none due",
                                 got.granted, got.error);
                    end
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("Mismatch: expected granted=%0b error=%0d, got granted=%0b error=%0d",
                                     want.granted, want.error, got.granted, got.error);
                        end
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                verdicts_due.push_back(decide_request(cmd.command, cmd.requester, cmd.window,
                                                      cmd.target, cmd.shared));
            end
            if (cfg_we)
            begin
                num_ranks = cfg_wdata;
            end
            pending <= verdicts_due.size();
            fail_count <= mismatches;
        end
    end

endmodule

### test/window_lock_manager_tb.sv
// Stimulus and verdict for the window lock manager regression.
module window_lock_manager_tb;
    import wlm_pkg::*;

    localparam int ITEMS        = 650;
    localparam int DIRECTED     = 25;
    localparam int PHASES       = 7;
    localparam int LIMIT_CYCLES = 200000;

    // One command word as the stimulus side builds it.
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [RANK_W-1:0] requester;
        logic [WIN_W-1:0]  window;
        logic [RANK_W-1:0] target;
        logic              shared;
    } cmd_word_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [NRANK_W-1:0] cfg_wdata;

    wlm_cmd_if cmd_ch ();
    wlm_rsp_if rsp_ch ();

    int pending;
    int fail_count;

    // Pacing of both sides; the percentages are the chance of an idle cycle.
    int   tx_idle_pct;
    int   rx_idle_pct;
    logic rx_hold;
    int   words_sent;
    int   cycle_count = 0;

    // Stimulus bookkeeping: how many windows exist and how many entries each
    // one had cleared when it was created. Entries beyond that count were
    // never written, so the stimulus must never address them in range.
    int                 windows_open;
    int                 cleared_ranks [MAX_WINDOWS_DEF];
    logic [NRANK_W-1:0] ranks_setting;
    logic [NRANK_W-1:0] phase_ranks [PHASES];

    window_lock_manager dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch)
    );

    window_lock_manager_checker lock_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd_ch),
        .rsp        (rsp_ch),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost response ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // The response side takes a word whenever it is not idling or held off.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rsp_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
        end
        else
        begin
            rsp_ch.ready <= 1'b0;
        end
    end

    // Once the unpaced third of the run is under way, the response side stops
    // taking words for a long stretch while the command side keeps offering,
    // so the response register fills and the block must stall its input.
    initial
    begin
        rx_hold <= 1'b0;
        while (words_sent < (2*ITEMS)/3 + 20)
        begin
            @(posedge clk);
        end
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Entries per window as the block sees the current setting.
    function automatic int eff_ranks();
        return (int'(ranks_setting) > MAX_RANKS_DEF) ? MAX_RANKS_DEF : int'(ranks_setting);
    endfunction

    function automatic cmd_word_t cmd_word(logic [CMD_W-1:0] op, logic [RANK_W-1:0] req,
                                           logic [WIN_W-1:0] win, logic [RANK_W-1:0] tgt,
                                           logic shr);
        cmd_word_t w;
        w.command = op;
        w.requester = req;
        w.window = win;
        w.target = tgt;
        w.shared = shr;
        return w;
    endfunction

    // Builds one random command word. Most words are well formed: they address
    // an existing window and pick ranks from a small pool so that locks collide
    // and owners come back to unlock. The rest are creates and raw noise.
    function automatic cmd_word_t random_word();
        int        roll;
        int        ranks;
        int        pool;
        int        pick;
        cmd_word_t w;
        ranks = eff_ranks();
        roll = $urandom_range(0, 99);
        w.command = CMD_CREATE;
        w.requester = RANK_W'($urandom_range(0, 63));
        w.window = WIN_W'($urandom_range(0, 15));
        w.target = RANK_W'($urandom_range(0, 63));
        w.shared = 1'($urandom_range(0, 1));
        if (roll < 5)
        begin
            return w;
        end
        if (roll < 13)
        begin
            w.command = CMD_W'($urandom_range(int'(CMD_LOCK), 7));
            return w;
        end
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            w.command = CMD_LOCK;
        end
        else if (pick < 65)
        begin
            w.command = CMD_UNLOCK;
        end
        else if (pick < 85)
        begin
            w.command = CMD_GET;
        end
        else
        begin
            w.command = CMD_SET;
        end
        if (windows_open > 0 && $urandom_range(0, 19) != 0)
        begin
            w.window = WIN_W'($urandom_range(0, windows_open - 1));
        end
        pool = (ranks < 4) ? ranks : 4;
        if (pool > 0 && $urandom_range(0, 4) != 0)
        begin
            w.requester = RANK_W'($urandom_range(0, pool - 1));
            w.target = RANK_W'($urandom_range(0, pool - 1));
        end
        return w;
    endfunction

    // Offers one word and returns at the edge where it is accepted. A word
    // that would reach an entry never cleared is steered elsewhere first.
    task automatic send_word(cmd_word_t w);
        int ranks;
        ranks = eff_ranks();
        if (words_sent < ITEMS/3)
        begin
            tx_idle_pct = 27;
            rx_idle_pct <= 84;
        end
        else if (words_sent < (2*ITEMS)/3)
        begin
            tx_idle_pct = 84;
            rx_idle_pct <= 27;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct <= 0;
        end
        if (w.command != CMD_CREATE && w.command <= CMD_SET && int'(w.window) < windows_open
            && int'(w.target) < ranks && int'(w.requester) < ranks
            && int'(w.target) >= cleared_ranks[w.window])
        begin
            if (cleared_ranks[w.window] > 0)
            begin
                w.target = RANK_W'($urandom_range(0, cleared_ranks[w.window] - 1));
            end
            else
            begin
                // A window created with no ranks has nothing safe to address.
                w.command = CMD_SET + 3'd1;
            end
        end
        if (w.command == CMD_CREATE && windows_open < MAX_WINDOWS_DEF)
        begin
            cleared_ranks[windows_open] = ranks;
            windows_open++;
        end
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= w.command;
        cmd_ch.requester <= w.requester;
        cmd_ch.window <= w.window;
        cmd_ch.target <= w.target;
        cmd_ch.shared <= w.shared;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        words_sent++;
    endtask

    // Stops offering and waits until every response word has come back. The
    // first edge lets the checker's count catch up with the last accepted word.
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_num_ranks(logic [NRANK_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        ranks_setting = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.command <= CMD_CREATE;
        cmd_ch.requester <= '0;
        cmd_ch.window <= '0;
        cmd_ch.target <= '0;
        cmd_ch.shared <= 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        words_sent = 0;
        windows_open = 0;
        ranks_setting = NUM_RANKS_RST;
        // Saturated, mid, zero, full, one, odd-wide and two-rank settings.
        phase_ranks = '{7'd100, 7'd4, 7'd0, 7'd64, 7'd1, 7'd63, 7'd2};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset setting of 64 ranks. A lock before any
        // window exists must be refused as window not created.
        send_word(cmd_word(CMD_LOCK, 6'd0, 4'd0, 6'd0, 1'b0));
        send_word(cmd_word(CMD_CREATE, 6'd63, 4'd15, 6'd63, 1'b1));
        send_word(cmd_word(CMD_CREATE, 6'd0, 4'd0, 6'd0, 1'b0));
        // Exclusive lock at the top rank: others are shut out, the owner is not.
        send_word(cmd_word(CMD_LOCK, 6'd63, 4'd0, 6'd63, 1'b0));
        send_word(cmd_word(CMD_LOCK, 6'd0, 4'd0, 6'd63, 1'b1));
        send_word(cmd_word(CMD_GET, 6'd0, 4'd0, 6'd63, 1'b0));
        send_word(cmd_word(CMD_SET, 6'd0, 4'd0, 6'd63, 1'b0));
        send_word(cmd_word(CMD_GET, 6'd63, 4'd0, 6'd63, 1'b0));
        send_word(cmd_word(CMD_SET, 6'd63, 4'd0, 6'd63, 1'b0));
        send_word(cmd_word(CMD_UNLOCK, 6'd0, 4'd0, 6'd63, 1'b0));
        send_word(cmd_word(CMD_UNLOCK, 6'd63, 4'd0, 6'd63, 1'b0));
        send_word(cmd_word(CMD_UNLOCK, 6'd63, 4'd0, 6'd63, 1'b0));
        // A shared lock lets others read but not write.
        send_word(cmd_word(CMD_LOCK, 6'd5, 4'd1, 6'd0, 1'b1));
        send_word(cmd_word(CMD_GET, 6'd9, 4'd1, 6'd0, 1'b0));
        send_word(cmd_word(CMD_SET, 6'd9, 4'd1, 6'd0, 1'b0));
        send_word(cmd_word(CMD_UNLOCK, 6'd5, 4'd1, 6'd0, 1'b0));
        send_word(cmd_word(CMD_GET, 6'd9, 4'd1, 6'd0, 1'b0));
        send_word(cmd_word(CMD_SET, 6'd9, 4'd1, 6'd0, 1'b0));
        send_word(cmd_word(CMD_LOCK, 6'd0, 4'd15, 6'd0, 1'b0));
        // Codes past the last command are refused without an error.
        send_word(cmd_word(CMD_SET + 3'd1, 6'd0, 4'd0, 6'd0, 1'b0));
        send_word(cmd_word(CMD_SET + 3'd2, 6'd1, 4'd1, 6'd1, 1'b1));
        send_word(cmd_word(CMD_SET + 3'd3, 6'd63, 4'd15, 6'd63, 1'b1));

        // With three ranks in use, a target or requester past them is out of range.
        drain_results();
        write_num_ranks(7'd3);
        send_word(cmd_word(CMD_LOCK, 6'd0, 4'd0, 6'd3, 1'b0));
        send_word(cmd_word(CMD_GET, 6'd63, 4'd0, 6'd0, 1'b0));
        send_word(cmd_word(CMD_LOCK, 6'd2, 4'd0, 6'd2, 1'b0));

        // Random phases, each under its own rank count, written while idle.
        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            write_num_ranks(phase_ranks[p]);
            repeat ((ITEMS - DIRECTED)/PHASES) send_word(random_word());
        end

        drain_results();
        repeat (80) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
